// File: rtl/core/query_text_lexer_macros.svh
// Assertion macros used by the lexer checker.
`ifndef QUERY_TEXT_LEXER_MACROS_SVH
`define QUERY_TEXT_LEXER_MACROS_SVH

// Property checked at every clock edge, reset included.
`define QTL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

// Property checked only while out of reset.
`define QTL_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

// File: rtl/core/qtl_pkg.sv
package qtl_pkg;

    localparam int MAX_QUERY_BYTES = 4096;
    localparam int MATCH_CHARS     = 9;
    localparam int PosMaxInt       = (MAX_QUERY_BYTES - 1 > 4095) ? 4095 : MAX_QUERY_BYTES - 1;
    localparam logic [11:0] POS_MAX = 12'(PosMaxInt);

    // token kinds
    localparam logic [5:0] KIND_END       = 6'd0;
    localparam logic [5:0] KIND_LBRACE    = 6'd1;
    localparam logic [5:0] KIND_RBRACE    = 6'd2;
    localparam logic [5:0] KIND_LBRACKET  = 6'd3;
    localparam logic [5:0] KIND_RBRACKET  = 6'd4;
    localparam logic [5:0] KIND_COMMA     = 6'd5;
    localparam logic [5:0] KIND_COLON     = 6'd6;
    localparam logic [5:0] KIND_STRING    = 6'd7;
    localparam logic [5:0] KIND_NUMBER    = 6'd8;
    localparam logic [5:0] KIND_IDENT     = 6'd9;
    localparam logic [5:0] KIND_KW_BASE   = 6'd10;
    localparam logic [5:0] KIND_OP_BASE   = 6'd37;
    localparam logic [5:0] KIND_ORANGE_BI = 6'd54;
    localparam logic [5:0] KIND_GREMB_BI  = 6'd55;
    localparam logic [5:0] KIND_ERR_CHAR  = 6'd56;
    localparam logic [5:0] KIND_ERR_OPER  = 6'd57;

    localparam logic ACT_END = 1'b1;

    typedef enum logic [3:0] {
        M_IDLE, M_STRING, M_MINUS, M_INT, M_DOT, M_FRAC, M_OPER, M_WORD
    } t_mode;

    typedef enum logic [1:0] {H_NONE, H_ORANGE, H_GREMB} t_held;

    typedef logic [MATCH_CHARS-1:0][7:0] t_prefix;

    // match pattern: up to nine chars, first char in the top byte
    typedef struct packed {
        logic [3:0]  len;
        logic [71:0] str;
    } t_pat;

    typedef struct packed {
        logic [5:0]  kind;
        logic [11:0] start;
        logic [7:0]  len;
    } t_tok;

    typedef struct packed {
        logic [1:0]      cnt;
        t_tok [2:0]      tok;
    } t_rbuf;

    typedef struct packed {
        logic  load;
        t_rbuf rb;
    } t_step;

    localparam t_pat PAT_ORANGE = {4'd6, "orange", 24'h0};
    localparam t_pat PAT_GREMB  = {4'd5, "gremb", 32'h0};
    localparam t_pat PAT_BI     = {4'd2, "bi", 56'h0};

    function automatic t_pat kw_pat(logic [4:0] i);
        case (i)
            5'd0:    return {4'd6, "funden", 24'h0};
            5'd1:    return {4'd8, "vietinfo", 8'h0};
            5'd2:    return {4'd6, "cochin", 24'h0};
            5'd3:    return {4'd6, "demlet", 24'h0};
            5'd4:    return {4'd6, "madeco", 24'h0};
            5'd5:    return {4'd5, "delco", 32'h0};
            5'd6:    return {4'd9, "madecoidu"};
            5'd7:    return {4'd9, "delecoidu"};
            5'd8:    return {4'd6, "gomail", 24'h0};
            5'd9:    return {4'd5, "ginan", 32'h0};
            5'd10:   return {4'd6, "cometi", 24'h0};
            5'd11:   return {4'd8, "tulaberk", 8'h0};
            5'd12:   return {4'd3, "usf", 48'h0};
            5'd13:   return {4'd5, "skill", 32'h0};
            5'd14:   return {4'd8, "exepanus", 8'h0};
            5'd15:   return {4'd4, "haar", 40'h0};
            5'd16:   return {4'd4, "lime", 40'h0};
            5'd17:   return {4'd6, "skopan", 24'h0};
            5'd18:   return {4'd3, "asc", 48'h0};
            5'd19:   return {4'd4, "desc", 40'h0};
            5'd20:   return {4'd3, "pou", 48'h0};
            5'd21:   return {4'd3, "sep", 48'h0};
            5'd22:   return {4'd3, "awr", 48'h0};
            5'd23:   return {4'd3, "mie", 48'h0};
            5'd24:   return {4'd3, "maf", 48'h0};
            5'd25:   return {4'd2, "tu", 56'h0};
            5'd26:   return {4'd2, "on", 56'h0};
            default: return '0;
        endcase
    endfunction

    function automatic t_pat op_pat(logic [4:0] i);
        case (i)
            5'd0:    return {4'd3, "$lh", 48'h0};
            5'd1:    return {4'd3, "$bh", 48'h0};
            5'd2:    return {4'd4, "$lhb", 40'h0};
            5'd3:    return {4'd4, "$bhb", 40'h0};
            5'd4:    return {4'd3, "$bg", 48'h0};
            5'd5:    return {4'd3, "$kc", 48'h0};
            5'd6:    return {4'd3, "$tg", 48'h0};
            5'd7:    return {4'd4, "$ktg", 40'h0};
            5'd8:    return {4'd5, "$tntt", 32'h0};
            5'd9:    return {4'd4, "$xau", 40'h0};
            5'd10:   return {4'd5, "$vand", 32'h0};
            5'd11:   return {4'd4, "$vor", 40'h0};
            5'd12:   return {4'd5, "$vnot", 32'h0};
            5'd13:   return {4'd4, "$quy", 40'h0};
            5'd14:   return {4'd4, "$don", 40'h0};
            5'd15:   return {4'd4, "$loi", 40'h0};
            5'd16:   return {4'd7, "$rasoat", 16'h0};
            default: return '0;
        endcase
    endfunction

    // exact match of the current word against one pattern
    function automatic logic pat_match(t_prefix pf, logic [7:0] tlen, t_pat p);
        logic ok;
        ok = (tlen == {4'd0, p.len});
        for (int n = 0; n < 9; n++) begin
            if (n < int'(p.len) && pf[n] != p.str[71-8*n -: 8]) ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] to_lower(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic [5:0] punct_kind(logic [7:0] c);
        case (c)
            "{":     return KIND_LBRACE;
            "}":     return KIND_RBRACE;
            "[":     return KIND_LBRACKET;
            "]":     return KIND_RBRACKET;
            ",":     return KIND_COMMA;
            ":":     return KIND_COLON;
            default: return KIND_END;
        endcase
    endfunction

    function automatic logic [11:0] sat_pos(logic [12:0] v);
        return (v > {1'b0, POS_MAX}) ? POS_MAX : v[11:0];
    endfunction

    function automatic t_rbuf rb_push(t_rbuf b, logic [5:0] k, logic [11:0] s,
                                      logic [7:0] l);
        if (b.cnt != 2'd3) begin
            b.tok[b.cnt] = '{kind: k, start: s, len: l};
            b.cnt = b.cnt + 2'd1;
        end
        return b;
    endfunction

    // send the held ident, if any
    function automatic t_rbuf rb_flush(t_rbuf b, t_held h, logic [11:0] s);
        if (h == H_ORANGE) return rb_push(b, KIND_IDENT, s, 8'd6);
        if (h == H_GREMB) return rb_push(b, KIND_IDENT, s, 8'd5);
        return b;
    endfunction

endpackage

// File: rtl/core/query_text_lexer.sv
// Query text lexer: takes one query byte (or an end-of-query mark) per request and
// returns tokens as kind, start offset and length, with last set on the final token
// that a request causes. A byte is taken every cycle as long as each byte yields at
// most one token and the receiver does not stall; a byte that yields two or three
// tokens (a held ident, a closing token and a new one) holds the input while the
// single token output port sends the rest. Input and token output are both registered.
module query_text_lexer
    import qtl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [7:0]  i_byte_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_token_kind,
    output logic [11:0] o_start_offset,
    output logic [7:0]  o_text_length,
    output logic        o_last
);

    t_step step;
    logic  out_free;

    qtl_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_action     (i_action),
        .i_byte_value (i_byte_value),
        .i_free       (out_free),
        .o_step       (step)
    );

    qtl_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .o_free         (out_free),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_kind   (o_token_kind),
        .o_start_offset (o_start_offset),
        .o_text_length  (o_text_length),
        .o_last         (o_last)
    );

endmodule

// File: rtl/core/qtl_scan.sv
module qtl_scan
    import qtl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_action,
    input  logic [7:0] i_byte_value,
    input  logic       i_free,
    output t_step      o_step
);

    // input register
    logic       r_in_valid;
    logic       r_action;
    logic [7:0] r_byte;

    // scanner state
    t_mode      r_mode;
    t_prefix    r_prefix;
    logic [11:0] r_tstart;
    logic [7:0] r_tlen;
    logic [11:0] r_bpos;
    t_held      r_held;
    logic [11:0] r_hstart;
    logic       r_stopped;

    t_mode      n_mode;
    t_prefix    n_prefix;
    logic [11:0] n_tstart;
    logic [7:0] n_tlen;
    logic [11:0] n_bpos;
    t_held      n_held;
    logic [11:0] n_hstart;
    logic       n_stopped;
    t_rbuf      n_rb;

    logic       fire;
    logic       kw_hit, op_hit;
    logic [4:0] kw_idx, op_idx;
    logic       is_bi, is_orange, is_gremb;

    assign fire    = r_in_valid && i_free;
    assign o_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_action <= i_action;
            r_byte   <= i_byte_value;
        end
    end

    // table compares on the word collected so far, lowest index wins
    always_comb begin
        kw_hit = 1'b0;
        kw_idx = '0;
        op_hit = 1'b0;
        op_idx = '0;
        for (int i = 26; i >= 0; i--) begin
            if (pat_match(r_prefix, r_tlen, kw_pat(5'(i)))) begin
                kw_hit = 1'b1;
                kw_idx = 5'(i);
            end
        end
        for (int i = 16; i >= 0; i--) begin
            if (pat_match(r_prefix, r_tlen, op_pat(5'(i)))) begin
                op_hit = 1'b1;
                op_idx = 5'(i);
            end
        end
        is_bi     = pat_match(r_prefix, r_tlen, PAT_BI);
        is_orange = pat_match(r_prefix, r_tlen, PAT_ORANGE);
        is_gremb  = pat_match(r_prefix, r_tlen, PAT_GREMB);
    end

    // one step of the scanner
    always_comb begin
        logic [7:0]  c;
        logic [11:0] pos;
        logic [11:0] diff;
        logic        eoq;
        logic        do_foper, do_fword, do_idle, do_end;
        logic        word_ch;

        c        = r_byte;
        pos      = r_bpos;
        eoq      = (r_action == ACT_END) || (r_byte == 8'd0);
        do_foper = 1'b0;
        do_fword = 1'b0;
        do_idle  = 1'b0;
        do_end   = 1'b0;
        word_ch  = is_alpha(c) || is_digit(c) || c == "_";
        diff     = pos - r_hstart;

        n_mode    = r_mode;
        n_prefix  = r_prefix;
        n_tstart  = r_tstart;
        n_tlen    = r_tlen;
        n_bpos    = r_bpos;
        n_held    = r_held;
        n_hstart  = r_hstart;
        n_stopped = r_stopped;
        n_rb      = '0;

        if (!r_stopped) begin
            if (eoq) begin
                // close the open token at end of query
                do_end = 1'b1;
                unique case (r_mode)
                    M_STRING: begin
                        n_rb   = rb_flush(n_rb, n_held, r_hstart);
                        n_held = H_NONE;
                        n_rb   = rb_push(n_rb, KIND_STRING, r_tstart, r_tlen);
                    end
                    M_MINUS: begin
                        n_rb      = rb_flush(n_rb, n_held, r_hstart);
                        n_held    = H_NONE;
                        n_rb      = rb_push(n_rb, KIND_ERR_CHAR, r_tstart, 8'd1);
                        n_stopped = 1'b1;
                    end
                    M_INT, M_FRAC: begin
                        n_rb   = rb_flush(n_rb, n_held, r_hstart);
                        n_held = H_NONE;
                        n_rb   = rb_push(n_rb, KIND_NUMBER, r_tstart, r_tlen);
                    end
                    M_DOT: begin
                        n_rb      = rb_flush(n_rb, n_held, r_hstart);
                        n_held    = H_NONE;
                        n_rb      = rb_push(n_rb, KIND_NUMBER, r_tstart, r_tlen);
                        n_rb      = rb_push(n_rb, KIND_ERR_CHAR,
                                            sat_pos({1'b0, r_tstart} + {5'd0, r_tlen}), 8'd1);
                        n_stopped = 1'b1;
                    end
                    M_OPER:  do_foper = 1'b1;
                    M_WORD:  do_fword = 1'b1;
                    default: ;
                endcase
            end else begin
                n_bpos = sat_pos({1'b0, pos} + 13'd1);
                unique case (r_mode)
                    M_STRING: begin
                        if (c == "\"") begin
                            n_rb   = rb_flush(n_rb, n_held, r_hstart);
                            n_held = H_NONE;
                            n_rb   = rb_push(n_rb, KIND_STRING, r_tstart, r_tlen);
                            n_mode = M_IDLE;
                        end else if (r_tlen != 8'd255) begin
                            n_tlen = r_tlen + 8'd1;
                        end
                    end
                    M_MINUS: begin
                        if (is_digit(c)) begin
                            n_tlen = r_tlen + 8'd1;
                            n_mode = M_INT;
                        end else begin
                            n_rb      = rb_flush(n_rb, n_held, r_hstart);
                            n_held    = H_NONE;
                            n_rb      = rb_push(n_rb, KIND_ERR_CHAR, r_tstart, 8'd1);
                            n_stopped = 1'b1;
                        end
                    end
                    M_INT, M_FRAC: begin
                        if (is_digit(c)) begin
                            if (r_tlen != 8'd255) n_tlen = r_tlen + 8'd1;
                        end else if (c == "." && r_mode == M_INT) begin
                            n_mode = M_DOT;
                        end else begin
                            n_rb    = rb_flush(n_rb, n_held, r_hstart);
                            n_held  = H_NONE;
                            n_rb    = rb_push(n_rb, KIND_NUMBER, r_tstart, r_tlen);
                            do_idle = 1'b1;
                        end
                    end
                    M_DOT: begin
                        if (is_digit(c)) begin
                            n_tlen = (r_tlen >= 8'd253) ? 8'd255 : r_tlen + 8'd2;
                            n_mode = M_FRAC;
                        end else begin
                            n_rb      = rb_flush(n_rb, n_held, r_hstart);
                            n_held    = H_NONE;
                            n_rb      = rb_push(n_rb, KIND_NUMBER, r_tstart, r_tlen);
                            n_rb      = rb_push(n_rb, KIND_ERR_CHAR,
                                                sat_pos({1'b0, r_tstart} + {5'd0, r_tlen}),
                                                8'd1);
                            n_stopped = 1'b1;
                        end
                    end
                    M_OPER, M_WORD: begin
                        if (word_ch || (r_mode == M_WORD && c == ".")) begin
                            for (int n = 0; n < MATCH_CHARS; n++) begin
                                if (r_tlen == 8'(n)) n_prefix[n] = to_lower(c);
                            end
                            if (r_tlen != 8'd255) n_tlen = r_tlen + 8'd1;
                        end else begin
                            do_foper = (r_mode == M_OPER);
                            do_fword = (r_mode == M_WORD);
                            do_idle  = 1'b1;
                        end
                    end
                    default: do_idle = 1'b1;
                endcase
            end

            // operator lookup
            if (do_foper) begin
                n_rb   = rb_flush(n_rb, n_held, r_hstart);
                n_held = H_NONE;
                if (op_hit) begin
                    n_rb = rb_push(n_rb, KIND_OP_BASE + {1'b0, op_idx}, r_tstart, r_tlen);
                end else begin
                    n_rb      = rb_push(n_rb, KIND_ERR_OPER, r_tstart, r_tlen);
                    n_stopped = 1'b1;
                end
            end

            // keyword lookup and bigram merge
            if (do_fword) begin
                if (kw_hit) begin
                    n_rb   = rb_flush(n_rb, n_held, r_hstart);
                    n_held = H_NONE;
                    n_rb   = rb_push(n_rb, KIND_KW_BASE + {1'b0, kw_idx}, r_tstart, r_tlen);
                end else if (r_held != H_NONE && is_bi) begin
                    n_rb   = rb_push(n_rb, (r_held == H_ORANGE) ? KIND_ORANGE_BI
                                                                : KIND_GREMB_BI,
                                     r_hstart, (diff > 12'd255) ? 8'd255 : diff[7:0]);
                    n_held = H_NONE;
                end else begin
                    n_rb   = rb_flush(n_rb, n_held, r_hstart);
                    n_held = H_NONE;
                    if (is_orange) begin
                        n_held   = H_ORANGE;
                        n_hstart = r_tstart;
                    end else if (is_gremb) begin
                        n_held   = H_GREMB;
                        n_hstart = r_tstart;
                    end else begin
                        n_rb = rb_push(n_rb, KIND_IDENT, r_tstart, r_tlen);
                    end
                end
            end

            // start of a new token between tokens
            if (do_idle && !n_stopped) begin
                n_mode = M_IDLE;
                if (is_space(c)) begin
                    n_mode = M_IDLE;
                end else if (punct_kind(c) != KIND_END) begin
                    n_rb   = rb_flush(n_rb, n_held, n_hstart);
                    n_held = H_NONE;
                    n_rb   = rb_push(n_rb, punct_kind(c), pos, 8'd1);
                end else if (c == "\"") begin
                    n_tstart = sat_pos({1'b0, pos} + 13'd1);
                    n_tlen   = 8'd0;
                    n_mode   = M_STRING;
                end else if (is_digit(c) || c == "-") begin
                    n_tstart = pos;
                    n_tlen   = 8'd1;
                    n_mode   = is_digit(c) ? M_INT : M_MINUS;
                end else if (c == "$" || is_alpha(c) || c == "_") begin
                    n_tstart    = pos;
                    n_tlen      = 8'd1;
                    n_prefix[0] = to_lower(c);
                    n_mode      = (c == "$") ? M_OPER : M_WORD;
                end else begin
                    n_rb      = rb_flush(n_rb, n_held, n_hstart);
                    n_held    = H_NONE;
                    n_rb      = rb_push(n_rb, KIND_ERR_CHAR, pos, 8'd1);
                    n_stopped = 1'b1;
                end
            end

            // end token of a clean query
            if (do_end && !n_stopped) begin
                n_rb   = rb_flush(n_rb, n_held, n_hstart);
                n_held = H_NONE;
                n_rb   = rb_push(n_rb, KIND_END, pos, 8'd0);
            end
        end

        // query boundary clears everything
        if (eoq) begin
            n_mode    = M_IDLE;
            n_prefix  = '0;
            n_tstart  = '0;
            n_tlen    = '0;
            n_bpos    = '0;
            n_held    = H_NONE;
            n_hstart  = '0;
            n_stopped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_IDLE;
            r_prefix  <= '0;
            r_tstart  <= '0;
            r_tlen    <= '0;
            r_bpos    <= '0;
            r_held    <= H_NONE;
            r_hstart  <= '0;
            r_stopped <= 1'b0;
        end else if (fire) begin
            r_mode    <= n_mode;
            r_prefix  <= n_prefix;
            r_tstart  <= n_tstart;
            r_tlen    <= n_tlen;
            r_bpos    <= n_bpos;
            r_held    <= n_held;
            r_hstart  <= n_hstart;
            r_stopped <= n_stopped;
        end
    end

    assign o_step.load = fire;
    assign o_step.rb   = n_rb;

endmodule

// File: rtl/core/qtl_out.sv
module qtl_out
    import qtl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_step       i_step,
    output logic        o_free,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_token_kind,
    output logic [11:0] o_start_offset,
    output logic [7:0]  o_text_length,
    output logic        o_last
);

    logic [1:0]  r_rem;
    logic [1:0]  r_head;
    t_tok [2:0]  r_tok;
    logic        take;

    assign o_valid = (r_rem != 2'd0);
    assign take    = o_valid && i_ready;
    // buffer can be reloaded when empty or when its last result leaves now
    assign o_free  = (r_rem == 2'd0) || (r_rem == 2'd1 && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_head <= '0;
        end else if (i_step.load) begin
            r_rem  <= i_step.rb.cnt;
            r_head <= '0;
        end else if (take) begin
            r_rem  <= r_rem - 2'd1;
            r_head <= r_head + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.load) r_tok <= i_step.rb.tok;
    end

    assign o_token_kind   = r_tok[r_head].kind;
    assign o_start_offset = r_tok[r_head].start;
    assign o_text_length  = r_tok[r_head].len;
    assign o_last         = (r_rem == 2'd1);

endmodule

// File: rtl/core/qtl_checker.sv
`include "query_text_lexer_macros.svh"

module qtl_checker
    import qtl_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_action,
    input logic [7:0]  i_byte_value,
    input logic        o_valid,
    input logic        i_ready,
    input logic [5:0]  o_token_kind,
    input logic [11:0] o_start_offset,
    input logic [7:0]  o_text_length,
    input logic        o_last
);

    // a stalled token stays offered
    `QTL_ASSERT_RUN(a_out_hold, o_valid && !i_ready |=> o_valid, "token dropped while stalled")
    // no token right after reset
    `QTL_ASSERT(a_rst_clear, !i_rst_n |=> !o_valid, "token valid after reset")
    // kinds stay in the defined range
    `QTL_ASSERT_RUN(a_kind_range, o_valid |-> o_token_kind <= KIND_ERR_OPER, "bad token kind")
    // the end token always closes its request, with zero length
    `QTL_ASSERT_RUN(a_end_last, o_valid && o_token_kind == KIND_END |-> o_last && o_text_length == 8'd0, "end token not last")

endmodule

bind query_text_lexer qtl_checker u_qtl_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import qtl_pkg::*;

    typedef struct {
        logic       act;
        logic [7:0] ch;
    } t_req;

    typedef struct {
        logic [5:0]  kind;
        logic [11:0] start;
        logic [7:0]  len;
        logic        last;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_action;
    logic [7:0]  i_byte_value;
    logic        o_valid;
    logic        i_ready;
    logic [5:0]  o_token_kind;
    logic [11:0] o_start_offset;
    logic [7:0]  o_text_length;
    logic        o_last;

    query_text_lexer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_byte_value   (i_byte_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_token_kind   (o_token_kind),
        .o_start_offset (o_start_offset),
        .o_text_length  (o_text_length),
        .o_last         (o_last)
    );

    localparam int ModeIdle = 0, ModeStr = 1, ModeMinus = 2, ModeInt = 3,
                   ModeDot = 4, ModeFrac = 5, ModeOper = 6, ModeWord = 7;
    localparam int HeldNone = 0, HeldOrange = 1, HeldGremb = 2;

    t_req    pending_q[$];
    t_result token_q[$];
    t_result step_toks[$];
    int      n_fail;
    int      n_cycles;
    bit      long_hold_req;

    // lexer state mirror
    int       lx_mode;
    byte      lx_pfx[9];
    int       lx_start, lx_len, lx_pos, lx_held, lx_held_start;
    bit       lx_stop;

    string kw_names[27] = '{"funden", "vietinfo", "cochin", "demlet", "madeco", "delco",
        "madecoidu", "delecoidu", "gomail", "ginan", "cometi", "tulaberk", "usf", "skill",
        "exepanus", "haar", "lime", "skopan", "asc", "desc", "pou", "sep", "awr", "mie",
        "maf", "tu", "on"};
    string op_names[17] = '{"$lh", "$bh", "$lhb", "$bhb", "$bg", "$kc", "$tg", "$ktg",
        "$tntt", "$xau", "$vand", "$vor", "$vnot", "$quy", "$don", "$loi", "$rasoat"};

    function automatic int clip_pos(int v);
        return v > int'(POS_MAX) ? int'(POS_MAX) : v;
    endfunction

    function automatic bit c_digit(int c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit c_alpha(int c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void tok_push(int k, int s, int l);
        t_result r;
        if (step_toks.size() >= 3) return;
        r.kind = k[5:0];
        r.start = s[11:0];
        r.len = l > 255 ? 8'd255 : l[7:0];
        r.last = 1'b0;
        step_toks.push_back(r);
    endfunction

    function automatic void held_out();
        if (lx_held != HeldNone) tok_push(KIND_IDENT, lx_held_start, lx_held == HeldOrange ? 6 : 5);
        lx_held = HeldNone;
    endfunction

    function automatic void tok_emit(int k, int s, int l);
        held_out();
        tok_push(k, s, l);
    endfunction

    function automatic void word_add(int c);
        if (lx_len < MATCH_CHARS) lx_pfx[lx_len] = (c >= "A" && c <= "Z") ? c + 32 : c;
        if (lx_len < 255) lx_len++;
    endfunction

    function automatic bit word_is(string s);
        if (s.len() != lx_len) return 0;
        for (int n = 0; n < s.len(); n++) begin
            if (n >= MATCH_CHARS || lx_pfx[n] != s[n]) return 0;
        end
        return 1;
    endfunction

    function automatic void word_close(int end_pos);
        for (int i = 0; i < 27; i++) begin
            if (word_is(kw_names[i])) begin
                tok_emit(KIND_KW_BASE + i, lx_start, lx_len);
                return;
            end
        end
        if (lx_held != HeldNone && word_is("bi")) begin
            tok_push(lx_held == HeldOrange ? KIND_ORANGE_BI : KIND_GREMB_BI, lx_held_start,
                     end_pos - lx_held_start);
            lx_held = HeldNone;
            return;
        end
        held_out();
        if (word_is("orange")) begin
            lx_held = HeldOrange;
            lx_held_start = lx_start;
        end else if (word_is("gremb")) begin
            lx_held = HeldGremb;
            lx_held_start = lx_start;
        end else begin
            tok_push(KIND_IDENT, lx_start, lx_len);
        end
    endfunction

    function automatic void oper_close();
        for (int i = 0; i < 17; i++) begin
            if (word_is(op_names[i])) begin
                tok_emit(KIND_OP_BASE + i, lx_start, lx_len);
                return;
            end
        end
        tok_emit(KIND_ERR_OPER, lx_start, lx_len);
        lx_stop = 1;
    endfunction

    function automatic void idle_char(int c, int pos);
        int pk;
        lx_mode = ModeIdle;
        if (c == " " || (c >= 9 && c <= 13)) return;
        pk = 0;
        case (c)
            "{": pk = KIND_LBRACE;
            "}": pk = KIND_RBRACE;
            "[": pk = KIND_LBRACKET;
            "]": pk = KIND_RBRACKET;
            ",": pk = KIND_COMMA;
            ":": pk = KIND_COLON;
            default: pk = 0;
        endcase
        if (pk != 0) begin
            tok_emit(pk, pos, 1);
            return;
        end
        lx_start = pos;
        lx_len = 0;
        if (c == "\"") begin
            lx_start = clip_pos(pos + 1);
            lx_mode = ModeStr;
        end else if (c_digit(c)) begin
            lx_len = 1;
            lx_mode = ModeInt;
        end else if (c == "-") begin
            lx_len = 1;
            lx_mode = ModeMinus;
        end else if (c == "$") begin
            word_add(c);
            lx_mode = ModeOper;
        end else if (c_alpha(c) || c == "_") begin
            word_add(c);
            lx_mode = ModeWord;
        end else begin
            tok_emit(KIND_ERR_CHAR, pos, 1);
            lx_stop = 1;
        end
    endfunction

    function automatic void lexer_clear();
        lx_mode = ModeIdle;
        foreach (lx_pfx[i]) lx_pfx[i] = 0;
        lx_start = 0;
        lx_len = 0;
        lx_pos = 0;
        lx_held = HeldNone;
        lx_held_start = 0;
        lx_stop = 0;
    endfunction

    function automatic void query_close();
        int pos;
        pos = lx_pos;
        if (!lx_stop) begin
            case (lx_mode)
                ModeStr: tok_emit(KIND_STRING, lx_start, lx_len);
                ModeMinus: begin
                    tok_emit(KIND_ERR_CHAR, lx_start, 1);
                    lx_stop = 1;
                end
                ModeInt, ModeFrac: tok_emit(KIND_NUMBER, lx_start, lx_len);
                ModeDot: begin
                    tok_emit(KIND_NUMBER, lx_start, lx_len);
                    tok_push(KIND_ERR_CHAR, clip_pos(lx_start + lx_len), 1);
                    lx_stop = 1;
                end
                ModeOper: oper_close();
                ModeWord: word_close(pos);
                default: ;
            endcase
            if (!lx_stop) begin
                held_out();
                tok_push(KIND_END, pos, 0);
            end
        end
    endfunction

    function automatic void query_char(int c);
        int pos;
        pos = lx_pos;
        if (lx_stop) return;
        case (lx_mode)
            ModeStr: begin
                if (c == "\"") begin
                    tok_emit(KIND_STRING, lx_start, lx_len);
                    lx_mode = ModeIdle;
                end else if (lx_len < 255) lx_len++;
            end
            ModeMinus: begin
                if (c_digit(c)) begin
                    lx_len++;
                    lx_mode = ModeInt;
                end else begin
                    tok_emit(KIND_ERR_CHAR, lx_start, 1);
                    lx_stop = 1;
                end
            end
            ModeInt, ModeFrac: begin
                if (c_digit(c)) begin
                    if (lx_len < 255) lx_len++;
                end else if (c == "." && lx_mode == ModeInt) begin
                    lx_mode = ModeDot;
                end else begin
                    tok_emit(KIND_NUMBER, lx_start, lx_len);
                    idle_char(c, pos);
                end
            end
            ModeDot: begin
                if (c_digit(c)) begin
                    lx_len = lx_len + 2 > 255 ? 255 : lx_len + 2;
                    lx_mode = ModeFrac;
                end else begin
                    tok_emit(KIND_NUMBER, lx_start, lx_len);
                    tok_push(KIND_ERR_CHAR, clip_pos(lx_start + lx_len), 1);
                    lx_stop = 1;
                end
            end
            ModeOper: begin
                if (c_alpha(c) || c_digit(c) || c == "_") word_add(c);
                else begin
                    oper_close();
                    if (!lx_stop) idle_char(c, pos);
                end
            end
            ModeWord: begin
                if (c_alpha(c) || c_digit(c) || c == "_" || c == ".") word_add(c);
                else begin
                    word_close(pos);
                    idle_char(c, pos);
                end
            end
            default: idle_char(c, pos);
        endcase
        lx_pos = clip_pos(pos + 1);
    endfunction

    // predict tokens of one accepted request
    function automatic void lex_predict(t_req r);
        step_toks.delete();
        if (r.act == ACT_END || r.ch == 8'd0) begin
            query_close();
            lexer_clear();
        end else begin
            query_char(r.ch);
        end
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[i]) token_q.push_back(step_toks[i]);
    endfunction

    // stimulus helpers
    function automatic void put_text(string s);
        t_req r;
        for (int i = 0; i < s.len(); i++) begin
            r.act = 1'b0;
            r.ch = s[i];
            pending_q.push_back(r);
        end
    endfunction

    function automatic void put_end(bit zero_byte);
        t_req r;
        r.act = zero_byte ? 1'b0 : ACT_END;
        r.ch = zero_byte ? 8'd0 : 8'($urandom);
        pending_q.push_back(r);
    endfunction

    function automatic string rand_word();
        string s;
        int n;
        case ($urandom_range(0, 5))
            0: s = kw_names[$urandom_range(0, 26)];
            1: s = op_names[$urandom_range(0, 16)];
            2: s = $urandom_range(0, 1) ? "orange bi" : "gremb bi";
            3: s = $urandom_range(0, 1) ? "OrAnGe" : "GREMB.x";
            default: begin
                s = "";
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++) s = {s, string'(byte'("a" + $urandom_range(0, 25)))};
            end
        endcase
        if ($urandom_range(0, 3) == 0 && s.len() > 0 && c_alpha(s[0])) s[0] = s[0] - 32;
        return s;
    endfunction

    function automatic string rand_piece();
        string s;
        string marks;
        marks = "{}[],:";
        case ($urandom_range(0, 9))
            0, 1, 2: s = rand_word();
            3: s = $sformatf("%0d", $urandom_range(0, 99999));
            4: s = $sformatf("-%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 99));
            5: s = {"\"", rand_word(), " x\""};
            6: begin
                s = " ";
                s[0] = marks[$urandom_range(0, 5)];
            end
            7: s = "\t";
            default: s = " ";
        endcase
        return s;
    endfunction

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // request driver: bursts and gaps
    int burst_left, gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (i_valid && o_ready) lex_predict('{act: i_action, ch: i_byte_value});
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    t_req r;
                    r = pending_q.pop_front();
                    i_valid <= 1'b1;
                    i_action <= r.act;
                    i_byte_value <= r.ch;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end else burst_left <= burst_left - 1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // token monitor and receiver stall pattern
    int stall_left, hold_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (token_q.size() == 0) begin
                    $error("token with nothing expected: kind %0d", o_token_kind);
                    n_fail++;
                end else begin
                    t_result e;
                    e = token_q.pop_front();
                    if (o_token_kind !== e.kind) begin
                        $error("token_kind exp %0d got %0d", e.kind, o_token_kind);
                        n_fail++;
                    end
                    if (o_start_offset !== e.start) begin
                        $error("start_offset exp %0d got %0d", e.start, o_start_offset);
                        n_fail++;
                    end
                    if (o_text_length !== e.len) begin
                        $error("text_length exp %0d got %0d", e.len, o_text_length);
                        n_fail++;
                    end
                    if (o_last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, o_last);
                        n_fail++;
                    end
                end
            end
            if (long_hold_req && hold_left == 0 && stall_left == 0) begin
                hold_left <= 300;
                i_ready <= 1'b0;
            end else if (hold_left > 1) begin
                hold_left <= hold_left - 1;
                i_ready <= 1'b0;
            end else if (hold_left == 1) begin
                hold_left <= 0;
                stall_left <= -1;
                i_ready <= 1'b1;
            end else if (n_cycles % 2000 < 600) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // one long hold-off, triggered once early while tokens are flowing
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == 20) long_hold_req <= 1'b1;
        else if (hold_left != 0) long_hold_req <= 1'b0;
        if (n_cycles > 400000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        string s;
        int n;
        n_fail = 0;
        n_cycles = 0;
        long_hold_req = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_action = 1'b0;
        i_byte_value = 8'd0;
        lexer_clear();
        // directed queries
        put_text("{}[],: \"ab\" -12.5 $RASOAT funden orange bi");
        put_end(0);
        put_text("gremb x 7. ");
        put_end(0);
        put_text("- ");
        put_end(1);
        put_text("$nope ");
        put_end(0);
        put_text("a");
        s = " ";
        s[0] = 8'hFF;
        put_text(s);
        put_end(0);
        put_text("\"open");
        put_end(0);
        put_text("ORANGE");
        put_end(0);
        put_text("3.x");
        put_end(0);
        put_text("-");
        put_end(0);
        // one long string to saturate the length
        put_text("\"");
        for (int i = 0; i < 260; i++) put_text("z");
        put_text("\" 1");
        put_end(0);
        // random queries
        n = 0;
        while (n < 30) begin
            s = "";
            for (int p = $urandom_range(1, 8); p > 0; p--) s = {s, rand_piece(), " "};
            if ($urandom_range(0, 7) == 0) begin
                s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(1, 255));
            end
            put_text(s);
            put_end($urandom_range(0, 4) == 0);
            n += s.len() + 1;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_q.size() == 0 && !i_valid);
        wait (token_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (n_fail == 0 && token_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/qtl_pkg.sv
rtl/core/qtl_scan.sv
rtl/core/qtl_out.sv
rtl/core/query_text_lexer.sv
rtl/core/qtl_checker.sv
tb/tb_top.sv
